@@ hw/rtl/tcw_pkg.sv @@
package tcw_pkg;

	// Screen geometry.
	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int NCELLS = COLS * ROWS;
	localparam int ADDR_W = $clog2(NCELLS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);

	// Field widths.
	localparam int REQ_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int CELL_W   = 2 * BYTE_W;
	localparam int IN_COL_W = 7;
	localparam int IN_ROW_W = 6;
	localparam int OUT_COL_W = 7;
	localparam int OUT_ROW_W = 5;
	localparam int CFG_IDX_W = 1;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR = 1'b1;

	// Character codes and reset attributes.
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_X       = 8'h58;
	localparam logic [BYTE_W-1:0] TEXT_ATTR_RST  = 8'd15;
	localparam logic [BYTE_W-1:0] ERROR_ATTR_RST = 8'd79;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [BYTE_W-1:0]   char_code;
		logic [BYTE_W-1:0]   attribute;
		logic                use_cursor;
		logic [IN_COL_W-1:0] col;
		logic [IN_ROW_W-1:0] row;
	} tcw_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_attr;
		logic [BYTE_W-1:0] error_attr;
	} tcw_cfg_t;

	typedef struct packed {
		logic [COL_W-1:0]  cur_col;
		logic [ROW_W-1:0]  cur_row;
		logic [BYTE_W-1:0] read_char;
		logic [BYTE_W-1:0] read_attr;
		logic              error_flag;
		logic              scrolled;
	} tcw_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RWAIT,
		ST_SCROLL,
		ST_SDRAIN,
		ST_FILL,
		ST_DONE
	} tcw_state_t;

endpackage

@@ hw/rtl/tcw_req_if.sv @@
interface tcw_req_if import tcw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [BYTE_W-1:0]   char_code;
	logic [BYTE_W-1:0]   attribute;
	logic                use_cursor;
	logic [IN_COL_W-1:0] col;
	logic [IN_ROW_W-1:0] row;

	modport source (
		output valid, req_type, char_code, attribute, use_cursor, col, row,
		input  ready
	);
	modport sink (
		input  valid, req_type, char_code, attribute, use_cursor, col, row,
		output ready
	);
endinterface

@@ hw/rtl/tcw_rsp_if.sv @@
interface tcw_rsp_if import tcw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUT_COL_W-1:0] cursor_col;
	logic [OUT_ROW_W-1:0] cursor_row;
	logic [BYTE_W-1:0]    read_char;
	logic [BYTE_W-1:0]    read_attr;
	logic                 error_flag;
	logic                 scrolled;

	modport source (
		output valid, cursor_col, cursor_row, read_char, read_attr, error_flag, scrolled,
		input  ready
	);
	modport sink (
		input  valid, cursor_col, cursor_row, read_char, read_attr, error_flag, scrolled,
		output ready
	);
endinterface

@@ hw/rtl/text_console_writer.sv @@
// Text-mode console engine with an 80 x 25 cell store (16-bit cells: attribute
// in the high byte, character in the low byte) and a cursor. Each request word
// gives one response word. Clear and scroll walk every cell through the single
// write port of the cell memory, one write a cycle, under the sequencer. After
// reset a clearing pass over all NCELLS (2000) cells zeroes the store before the
// first request is taken; configuration writes are taken at any time. A new
// request is taken while a finished response still waits in the output register.
module text_console_writer import tcw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	tcw_req_if.sink              req,
	tcw_rsp_if.source            rsp
);

	tcw_cfg_t cfg_q;
	tcw_req_t req_word;
	tcw_res_t eng_res;
	logic     eng_ready;
	logic     eng_done;
	logic     out_free;
	logic     out_valid_q;

	logic [OUT_COL_W-1:0] out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [BYTE_W-1:0]    out_char_q;
	logic [BYTE_W-1:0]    out_attr_q;
	logic                 out_err_q;
	logic                 out_scr_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_attr  <= TEXT_ATTR_RST;
			cfg_q.error_attr <= ERROR_ATTR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEXT_ATTR:  cfg_q.text_attr  <= cfg_data;
				CFG_ERROR_ATTR: cfg_q.error_attr <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req_word.req_type   = req.req_type;
	assign req_word.char_code  = req.char_code;
	assign req_word.attribute  = req.attribute;
	assign req_word.use_cursor = req.use_cursor;
	assign req_word.col        = req.col;
	assign req_word.row        = req.row;
	assign req.ready           = eng_ready;

	tcw_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_accept(req.valid && eng_ready),
		.req_in    (req_word),
		.cfg       (cfg_q),
		.out_free  (out_free),
		.ready     (eng_ready),
		.done      (eng_done),
		.res       (eng_res)
	);

	// Output register: the slot is free when empty or being taken.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			out_col_q  <= OUT_COL_W'(eng_res.cur_col);
			out_row_q  <= OUT_ROW_W'(eng_res.cur_row);
			out_char_q <= eng_res.read_char;
			out_attr_q <= eng_res.read_attr;
			out_err_q  <= eng_res.error_flag;
			out_scr_q  <= eng_res.scrolled;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.read_char  = out_char_q;
	assign rsp.read_attr  = out_attr_q;
	assign rsp.error_flag = out_err_q;
	assign rsp.scrolled   = out_scr_q;

	// A finished word never overwrites one that is still waiting.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> out_free)
		else $error("result finished while output register was full");

	// The cursor always points inside the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |-> (32'(eng_res.cur_row) < ROWS) && (32'(eng_res.cur_col) < COLS))
		else $error("cursor outside the screen");

	// A put that scrolls cannot also report a bad position.
	a_scroll_err: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done && eng_res.scrolled |-> !eng_res.error_flag)
		else $error("scroll reported together with position error");

	// A finished word shows up on the response channel next cycle.
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |=> rsp.valid)
		else $error("finished result not presented");

endmodule

@@ hw/rtl/tcw_ram.sv @@
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/tcw_engine.sv @@
module tcw_engine import tcw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_accept,
	input  tcw_req_t req_in,
	input  tcw_cfg_t cfg,
	input  logic     out_free,
	output logic     ready,
	output logic     done,
	output tcw_res_t res
);

	localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(NCELLS - 1);
	localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(NCELLS - COLS - 1);

	tcw_state_t state_q, state_d;

	tcw_req_t          req_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [CELL_W-1:0] fill_q;
	logic              pend_q;
	logic              init_q;
	logic [BYTE_W-1:0] rchar_q;
	logic [BYTE_W-1:0] rattr_q;
	logic              err_q;
	logic              scr_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Position decode of the held request.
	logic              in_range;
	logic              is_nl;
	logic [COL_W-1:0]  pos_col;
	logic [ROW_W-1:0]  pos_row;
	logic [ADDR_W-1:0] exp_addr;
	logic [ADDR_W-1:0] put_addr;
	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic [ROW_W:0]    row_adv;
	logic              col_wrap;
	logic              wrap;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;

	assign in_range = (32'(req_q.col) < COLS) && (32'(req_q.row) < ROWS);
	assign is_nl    = (req_q.char_code == CH_NEWLINE);
	assign pos_col  = req_q.use_cursor ? cur_col_q : COL_W'(req_q.col);
	assign pos_row  = req_q.use_cursor ? cur_row_q : ROW_W'(req_q.row);
	assign exp_addr = ADDR_W'(32'(req_q.row) * COLS + 32'(req_q.col));
	assign put_addr = ADDR_W'(32'(pos_row) * COLS + 32'(pos_col));

	// Cursor advance: next column, or start of the next row, then scroll check.
	assign col_inc  = {1'b0, pos_col} + 1'b1;
	assign row_inc  = {1'b0, pos_row} + 1'b1;
	assign col_wrap = (col_inc == (COL_W + 1)'(COLS));
	assign row_adv  = (is_nl || col_wrap) ? row_inc : {1'b0, pos_row};
	assign wrap     = (row_adv == (ROW_W + 1)'(ROWS));
	assign nxt_col  = (is_nl || col_wrap) ? '0 : col_inc[COL_W-1:0];
	assign nxt_row  = wrap ? ROW_W'(ROWS - 1) : row_adv[ROW_W-1:0];

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(NCELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = put_addr;
		ram_wdata = {req_q.attribute, req_q.char_code};
		ram_raddr = exp_addr;
		done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (req_q.req_type)
					REQ_PUT: begin
						if (!req_q.use_cursor && !in_range) begin
							ram_we    = 1'b1;
							ram_waddr = LAST_ADDR;
							ram_wdata = {cfg.error_attr, CH_X};
							state_d   = ST_DONE;
						end else begin
							ram_we  = !is_nl;
							state_d = wrap ? ST_SCROLL : ST_DONE;
						end
					end
					REQ_CLEAR: state_d = ST_FILL;
					REQ_READ:  state_d = in_range ? ST_RWAIT : ST_DONE;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_RWAIT: state_d = ST_DONE;
			ST_SCROLL: begin
				// Read one row below, write the word read last cycle.
				ram_we    = pend_q;
				ram_waddr = wr_addr_q;
				ram_wdata = ram_rdata;
				ram_raddr = addr_q + ADDR_W'(COLS);
				if (addr_q == SCROLL_LAST) begin
					state_d = ST_SDRAIN;
				end
			end
			ST_SDRAIN: begin
				ram_we    = 1'b1;
				ram_waddr = wr_addr_q;
				ram_wdata = ram_rdata;
				state_d   = ST_FILL;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				ram_wdata = fill_q;
				if (addr_q == LAST_ADDR) begin
					state_d = init_q ? ST_IDLE : ST_DONE;
				end
			end
			ST_DONE: begin
				done = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer control registers: cursor, sweep address and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			addr_q    <= '0;
			fill_q    <= '0;
			pend_q    <= 1'b0;
			init_q    <= 1'b1;
		end else begin
			case (state_q)
				ST_EXEC: begin
					addr_q <= '0;
					pend_q <= 1'b0;
					if (req_q.req_type == REQ_PUT && (req_q.use_cursor || in_range)) begin
						cur_col_q <= nxt_col;
						cur_row_q <= nxt_row;
					end
					if (req_q.req_type == REQ_CLEAR) begin
						cur_col_q <= '0;
						cur_row_q <= '0;
						fill_q    <= {cfg.text_attr, CH_SPACE};
					end
				end
				ST_SCROLL: begin
					pend_q <= 1'b1;
					addr_q <= addr_q + 1'b1;
				end
				ST_SDRAIN: fill_q <= '0;
				ST_FILL: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						init_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Request capture and result word.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= req_in;
		end
		if (state_q == ST_SCROLL) begin
			wr_addr_q <= addr_q;
		end
		if (state_q == ST_EXEC) begin
			rchar_q <= '0;
			rattr_q <= '0;
			err_q   <= ((req_q.req_type == REQ_PUT) && !req_q.use_cursor && !in_range) ||
			           ((req_q.req_type == REQ_READ) && !in_range);
			scr_q   <= (req_q.req_type == REQ_PUT) && (req_q.use_cursor || in_range) && wrap;
		end
		if (state_q == ST_RWAIT) begin
			rchar_q <= ram_rdata[BYTE_W-1:0];
			rattr_q <= ram_rdata[CELL_W-1:BYTE_W];
		end
	end

	assign ready = (state_q == ST_IDLE);

	assign res.cur_col    = cur_col_q;
	assign res.cur_row    = cur_row_q;
	assign res.read_char  = rchar_q;
	assign res.read_attr  = rattr_q;
	assign res.error_flag = err_q;
	assign res.scrolled   = scr_q;

endmodule
